// File: rtl/core/adv_data_name_filter_assert.svh
// Assertion macros for the name filter checkers.
`ifndef ADV_DATA_NAME_FILTER_ASSERT_SVH
`define ADV_DATA_NAME_FILTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ADNF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define ADNF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/adnf_pkg.sv
// ----------------------------------------------------------------------------
// adnf_pkg
// Shared types and constants of the advertising data name filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adnf_pkg;

   localparam int NAME_BUFFER      = 29;
   localparam int MAX_TARGET_BYTES = 8;
   localparam int NAME_MAX         = NAME_BUFFER - 1;
   localparam int NAME_INDEX_W     = $clog2(NAME_BUFFER);
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 64;

   localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
   localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;

   localparam logic [63:0] TARGET_NAME_RESET   = 64'd4937793;
   localparam logic [3:0]  TARGET_LENGTH_RESET = 4'd3;

   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_ADV  = 2'd1;
   localparam logic [1:0] SRC_RESP = 2'd2;

   localparam logic REG_TARGET_NAME   = 1'b0;
   localparam logic REG_TARGET_LENGTH = 1'b1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       in_scan_response;
      logic [7:0] section_length;
      logic       last_of_report;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] name_source;
      logic       adv_malformed;
      logic       resp_malformed;
   } rsp_type;

   typedef struct packed {
      logic [63:0] target_name;
      logic [3:0]  target_length;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/adnf_csr.sv
// ----------------------------------------------------------------------------
// adnf_csr
// APB register file holding the target name and its compare length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adnf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [adnf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [adnf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [adnf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output adnf_pkg::cfg_type                     cfg
);

   logic [63:0] target_name_ff, target_name_in;
   logic [3:0]  target_length_ff, target_length_in;
   logic        wr_en;
   logic        reg_sel;

   assign reg_sel = paddr[3];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      target_name_in   = target_name_ff;
      target_length_in = target_length_ff;
      if (wr_en) begin
         case (reg_sel)
            adnf_pkg::REG_TARGET_NAME:   target_name_in   = pwdata[63:0];
            adnf_pkg::REG_TARGET_LENGTH: target_length_in = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_name_ff   <= adnf_pkg::TARGET_NAME_RESET;
         target_length_ff <= adnf_pkg::TARGET_LENGTH_RESET;
      end else begin
         target_name_ff   <= target_name_in;
         target_length_ff <= target_length_in;
      end
   end

   always_comb begin
      case (reg_sel)
         adnf_pkg::REG_TARGET_NAME:   prdata = target_name_ff;
         adnf_pkg::REG_TARGET_LENGTH: prdata = {60'd0, target_length_ff};
         default:                     prdata = '0;
      endcase
   end

   assign cfg.target_name   = target_name_ff;
   assign cfg.target_length = target_length_ff;

endmodule

`default_nettype wire

// File: rtl/core/adnf_parse.sv
// ----------------------------------------------------------------------------
// adnf_parse
// Per-report parser state and the one-byte step of the field walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adnf_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire adnf_pkg::req_type  item,
   input  wire adnf_pkg::cfg_type  cfg,
   output adnf_pkg::rsp_type       result
);

   localparam int NIW = adnf_pkg::NAME_INDEX_W;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_VALUE,
      PH_DONE
   } phase_type;

   logic [7:0]           section_left_ff, section_left_in;
   logic [7:0]           field_left_ff, field_left_in;
   phase_type            phase_ff, phase_in;
   logic                 field_is_name_ff, field_is_name_in;
   logic [NIW-1:0]       name_index_ff, name_index_in;
   logic                 name_equal_ff, name_equal_in;
   logic                 name_term_ff, name_term_in;
   logic [1:0]           found_source_ff, found_source_in;
   logic [1:0]           error_flags_ff, error_flags_in;

   logic [7:0]           sl_v, fl_v;
   phase_type            ph_v;
   logic                 fin_v, eq_v, term_v, do_finish;
   logic [NIW-1:0]       ni_v;
   logic [1:0]           src_v, err_v;
   logic [3:0]           tlen;
   logic [7:0]           b;
   logic                 resp;
   logic [7:0]           tgt_byte;

   assign b    = item.byte_value;
   assign resp = item.in_scan_response;
   assign tlen = (cfg.target_length > 4'(adnf_pkg::MAX_TARGET_BYTES)) ?
                 4'(adnf_pkg::MAX_TARGET_BYTES) : cfg.target_length;
   assign tgt_byte = cfg.target_name[{name_index_ff[2:0], 3'b000} +: 8];

   always_comb begin
      sl_v      = section_left_ff;
      fl_v      = field_left_ff;
      ph_v      = phase_ff;
      fin_v     = field_is_name_ff;
      ni_v      = name_index_ff;
      eq_v      = name_equal_ff;
      term_v    = name_term_ff;
      src_v     = found_source_ff;
      err_v     = error_flags_ff;
      do_finish = 1'b0;

      if (item.section_length != 8'd0) begin
         if (sl_v == 8'd0) begin
            sl_v  = item.section_length;
            ph_v  = PH_LEN;
            fl_v  = 8'd0;
            fin_v = 1'b0;
         end
         if (src_v == adnf_pkg::SRC_NONE) begin
            case (ph_v)
               PH_LEN: begin
                  if (sl_v > 8'd1 && b != 8'd0) begin
                     if (b >= sl_v) begin
                        if (resp) err_v[1] = 1'b1;
                        else      err_v[0] = 1'b1;
                        ph_v = PH_DONE;
                     end else begin
                        fl_v = b;
                        ph_v = PH_TYPE;
                     end
                  end
               end
               PH_TYPE: begin
                  fl_v = fl_v - 8'd1;
                  if (b == adnf_pkg::TYPE_SHORT_NAME || b == adnf_pkg::TYPE_FULL_NAME) begin
                     fin_v  = 1'b1;
                     ni_v   = '0;
                     eq_v   = 1'b1;
                     term_v = 1'b0;
                     if (fl_v == 8'd0) do_finish = 1'b1;
                     else              ph_v = PH_VALUE;
                  end else begin
                     ph_v = (fl_v == 8'd0) ? PH_LEN : PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  fl_v = fl_v - 8'd1;
                  if (fin_v) begin
                     if (!term_v) begin
                        if (b == 8'd0) begin
                           term_v = 1'b1;
                        end else begin
                           if (ni_v >= {1'b0, tlen} || b != tgt_byte) eq_v = 1'b0;
                           ni_v = ni_v + NIW'(1);
                           if (ni_v >= NIW'(adnf_pkg::NAME_MAX)) term_v = 1'b1;
                        end
                     end
                     if (fl_v == 8'd0) do_finish = 1'b1;
                  end else if (fl_v == 8'd0) begin
                     ph_v = PH_LEN;
                  end
               end
               default: ;
            endcase
         end
         sl_v = sl_v - 8'd1;
      end

      // close a name cut short by the end of the report
      if (item.last_of_report && src_v == adnf_pkg::SRC_NONE &&
          ph_v == PH_VALUE && fin_v) begin
         do_finish = 1'b1;
      end

      if (do_finish) begin
         if (ni_v != '0) begin
            src_v = resp ? adnf_pkg::SRC_RESP : adnf_pkg::SRC_ADV;
         end else begin
            eq_v   = 1'b1;
            term_v = 1'b0;
         end
         fin_v = 1'b0;
         ph_v  = PH_DONE;
      end
   end

   always_comb begin
      result.matched        = (src_v != adnf_pkg::SRC_NONE) && (tlen != 4'd0) && eq_v &&
                              (ni_v == {1'b0, tlen});
      result.name_source    = src_v;
      result.adv_malformed  = err_v[0];
      result.resp_malformed = err_v[1];
   end

   always_comb begin
      if (item.last_of_report) begin
         section_left_in  = 8'd0;
         field_left_in    = 8'd0;
         phase_in         = PH_LEN;
         field_is_name_in = 1'b0;
         name_index_in    = '0;
         name_equal_in    = 1'b1;
         name_term_in     = 1'b0;
         found_source_in  = adnf_pkg::SRC_NONE;
         error_flags_in   = 2'd0;
      end else begin
         section_left_in  = sl_v;
         field_left_in    = fl_v;
         phase_in         = ph_v;
         field_is_name_in = fin_v;
         name_index_in    = ni_v;
         name_equal_in    = eq_v;
         name_term_in     = term_v;
         found_source_in  = src_v;
         error_flags_in   = err_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_left_ff  <= 8'd0;
         field_left_ff    <= 8'd0;
         phase_ff         <= PH_LEN;
         field_is_name_ff <= 1'b0;
         name_index_ff    <= '0;
         name_equal_ff    <= 1'b1;
         name_term_ff     <= 1'b0;
         found_source_ff  <= adnf_pkg::SRC_NONE;
         error_flags_ff   <= 2'd0;
      end else if (step_en) begin
         section_left_ff  <= section_left_in;
         field_left_ff    <= field_left_in;
         phase_ff         <= phase_in;
         field_is_name_ff <= field_is_name_in;
         name_index_ff    <= name_index_in;
         name_equal_ff    <= name_equal_in;
         name_term_ff     <= name_term_in;
         found_source_ff  <= found_source_in;
         error_flags_ff   <= error_flags_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/adv_data_name_filter.sv
// ----------------------------------------------------------------------------
// adv_data_name_filter
// Walks the fields of a scan report and flags a match on the device name.
//
//   channel   dir   payload                  handshake
//   req       in    adnf_pkg::req_type       req_valid / req_stall
//   rsp       out   adnf_pkg::rsp_type       rsp_valid / rsp_stall
//   csr       in    target name, length      APB, 64-bit data
//
// One word per clock unless stalled; the parser step sits between the input
// register and the result register, which takes a report's result.
// Words that do not end a report are taken even while a result waits.
// A word ending a report stalls only while the result register is held.
// Synchronous reset clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adv_data_name_filter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire adnf_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output adnf_pkg::rsp_type                     rsp_data,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [adnf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [adnf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [adnf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   adnf_pkg::cfg_type  cfg;
   adnf_pkg::req_type  in_data_ff, in_data_in;
   logic               in_vld_ff, in_vld_in;
   adnf_pkg::rsp_type  out_data_ff, out_data_in, step_result;
   logic               out_vld_ff, out_vld_in;
   logic               advance;

   adnf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   adnf_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign advance   = in_vld_ff & (~in_data_ff.last_of_report | ~out_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      if (!req_stall) begin
         in_vld_in  = req_valid;
         in_data_in = req_data;
      end
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      if (advance && in_data_ff.last_of_report) begin
         out_vld_in  = 1'b1;
         out_data_in = step_result;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/adnf_checker.sv
// ----------------------------------------------------------------------------
// adnf_checker
// Port-level checks on the result channel of the name filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "adv_data_name_filter_assert.svh"

module adnf_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire adnf_pkg::rsp_type  rsp_data
);

   `ADNF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")
   `ADNF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "rsp changed")
   `ADNF_ASSERT_NOW(a_src_code, clock, reset, rsp_valid, rsp_data.name_source != 2'd3, "bad source")
   `ADNF_ASSERT_NOW(a_match_src, clock, reset, rsp_valid && rsp_data.matched, rsp_data.name_source != adnf_pkg::SRC_NONE, "match without name")

endmodule

bind adv_data_name_filter adnf_checker u_adnf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: dv/adv_data_name_filter_checker.sv
// ----------------------------------------------------------------------------
// adv_data_name_filter_checker
// Predicts and checks the result words of the advertising data name filter.
//
// Watches the req, rsp and csr ports of the block. Keeps its own copy of the
// target registers and of the per-report parse state. For each report it
// works out the result word that the report's last word must produce and
// queues it. Each accepted result word is compared field by field with the
// oldest queued result. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adv_data_name_filter_checker
   import adnf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending,
   output int                    results_seen,
   output int                    matches_seen
);

   localparam logic [1:0] ADV_OVERRUN  = 2'b01;
   localparam logic [1:0] RESP_OVERRUN = 2'b10;
   localparam int         SHOWN_FAILS  = 10;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_VALUE,
      PH_DONE
   } phase_type;

   logic [63:0] tgt_chars;
   logic [3:0]  tgt_len;

   logic [7:0]  sec_remaining;
   logic [7:0]  fld_remaining;
   phase_type   walk_phase;
   logic        in_name_field;
   logic [4:0]  name_count;
   logic        name_still_equal;
   logic        name_ended;
   logic [1:0]  name_origin;
   logic [1:0]  overrun_flags;

   rsp_type     expected_results[$];

   function automatic int compare_span();
      int span;
      span = int'(tgt_len);
      if (span > MAX_TARGET_BYTES) begin
         span = MAX_TARGET_BYTES;
      end
      return span;
   endfunction

   task automatic clear_report();
      sec_remaining    = '0;
      fld_remaining    = '0;
      walk_phase       = PH_LEN;
      in_name_field    = 1'b0;
      name_count       = '0;
      name_still_equal = 1'b1;
      name_ended       = 1'b0;
      name_origin      = SRC_NONE;
      overrun_flags    = '0;
   endtask

   task automatic close_name(input logic resp);
      if (name_count > 0) begin
         name_origin = resp ? SRC_RESP : SRC_ADV;
      end else begin
         name_still_equal = 1'b1;
         name_ended       = 1'b0;
      end
      in_name_field = 1'b0;
      walk_phase    = PH_DONE;
   endtask

   task automatic take_name_byte(input logic [7:0] b);
      int span;
      span = compare_span();
      if (!name_ended) begin
         if (b == 8'h00) begin
            name_ended = 1'b1;
         end else begin
            if (int'(name_count) >= span || b != tgt_chars[8*name_count +: 8]) begin
               name_still_equal = 1'b0;
            end
            name_count = name_count + 1'b1;
            if (int'(name_count) >= NAME_MAX) begin
               name_ended = 1'b1;
            end
         end
      end
   endtask

   task automatic walk_byte(input logic [7:0] b, input logic resp);
      case (walk_phase)
         PH_LEN: begin
            if (sec_remaining > 1 && b != 8'h00) begin
               if (b >= sec_remaining) begin
                  overrun_flags = overrun_flags | (resp ? RESP_OVERRUN : ADV_OVERRUN);
                  walk_phase    = PH_DONE;
               end else begin
                  fld_remaining = b;
                  walk_phase    = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            fld_remaining = fld_remaining - 1'b1;
            if (b == TYPE_SHORT_NAME || b == TYPE_FULL_NAME) begin
               in_name_field    = 1'b1;
               name_count       = '0;
               name_still_equal = 1'b1;
               name_ended       = 1'b0;
               if (fld_remaining == 0) begin
                  close_name(resp);
               end else begin
                  walk_phase = PH_VALUE;
               end
            end else if (fld_remaining == 0) begin
               walk_phase = PH_LEN;
            end else begin
               walk_phase = PH_VALUE;
            end
         end
         PH_VALUE: begin
            fld_remaining = fld_remaining - 1'b1;
            if (in_name_field) begin
               take_name_byte(b);
               if (fld_remaining == 0) begin
                  close_name(resp);
               end
            end else if (fld_remaining == 0) begin
               walk_phase = PH_LEN;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic absorb_word(input req_type w);
      rsp_type res;
      int      span;
      if (w.section_length != 0) begin
         if (sec_remaining == 0) begin
            sec_remaining = w.section_length;
            walk_phase    = PH_LEN;
            fld_remaining = '0;
            in_name_field = 1'b0;
         end
         if (name_origin == SRC_NONE) begin
            walk_byte(w.byte_value, w.in_scan_response);
         end
         sec_remaining = sec_remaining - 1'b1;
      end
      if (w.last_of_report) begin
         if (name_origin == SRC_NONE && walk_phase == PH_VALUE && in_name_field) begin
            close_name(w.in_scan_response);
         end
         span               = compare_span();
         res.matched        = name_origin != SRC_NONE && span != 0 && name_still_equal &&
                              int'(name_count) == span;
         res.name_source    = name_origin;
         res.adv_malformed  = overrun_flags[0];
         res.resp_malformed = overrun_flags[1];
         expected_results.push_back(res);
         clear_report();
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count = fail_count + 1;
      if (fail_count <= SHOWN_FAILS) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         note_failure($sformatf("unexpected result word %b", got));
      end else begin
         want = expected_results.pop_front();
         if (got.matched !== want.matched || got.name_source !== want.name_source ||
             got.adv_malformed !== want.adv_malformed ||
             got.resp_malformed !== want.resp_malformed) begin
            note_failure($sformatf({"result mismatch: expected matched %b source %0d ",
                                    "adv_bad %b resp_bad %b, got matched %b source %0d ",
                                    "adv_bad %b resp_bad %b"},
                                   want.matched, want.name_source, want.adv_malformed,
                                   want.resp_malformed, got.matched, got.name_source,
                                   got.adv_malformed, got.resp_malformed));
         end
         results_seen = results_seen + 1;
         if (got.matched === 1'b1) begin
            matches_seen = matches_seen + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tgt_chars    = TARGET_NAME_RESET;
         tgt_len      = TARGET_LENGTH_RESET;
         clear_report();
         expected_results.delete();
         fail_count   = 0;
         results_seen = 0;
         matches_seen = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_TARGET_NAME, 3'b000}) begin
               tgt_chars = pwdata;
            end else if (paddr == {REG_TARGET_LENGTH, 3'b000}) begin
               tgt_len = pwdata[3:0];
            end
         end
         if (req_valid && !req_stall) begin
            absorb_word(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: dv/tb_adv_data_name_filter.sv
// ----------------------------------------------------------------------------
// tb_adv_data_name_filter
// Stimulus and verdict for the advertising data name filter.
//
// Sends a short directed set of scan reports, then random reports under nine
// target settings: well-formed field chains with names drawn from the target,
// overruns, empty items, cut reports and raw noise. Both channels idle at
// random under two of three idling mixes; the receiver also holds off for a long
// stretch once. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adv_data_name_filter;
   import adnf_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 200;
   localparam int SESSION_WORDS = 128;
   localparam int SESSIONS      = 9;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int results_seen;
   int matches_seen;

   int   cycle_count   = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_kick     = 1'b0;
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;

   int          words_sent   = 0;
   int          reports_sent = 0;
   logic [63:0] cur_name     = TARGET_NAME_RESET;
   logic [3:0]  cur_len      = TARGET_LENGTH_RESET;
   req_type     report_words[$];

   adv_data_name_filter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   adv_data_name_filter_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .results_seen(results_seen),
      .matches_seen(matches_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stall, or a long hold when kicked
   always @(negedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic void add_word(input logic [7:0] b, input logic resp,
                                    input logic [7:0] slen, input logic last);
      req_type w;
      w.byte_value       = b;
      w.in_scan_response = resp;
      w.section_length   = slen;
      w.last_of_report   = last;
      report_words.push_back(w);
   endfunction

   function automatic void make_name(ref logic [7:0] v[$]);
      int span;
      int n;
      span = (int'(cur_len) > MAX_TARGET_BYTES) ? MAX_TARGET_BYTES : int'(cur_len);
      v.delete();
      case ($urandom_range(0, 7))
         0, 1: n = span;
         2: n = $urandom_range(0, span);
         default: n = 0;
      endcase
      case ($urandom_range(0, 7))
         3: begin
            for (int i = 0; i < span; i++) v.push_back(cur_name[8*i +: 8]);
            repeat ($urandom_range(1, 3)) v.push_back(8'($urandom_range(1, 255)));
         end
         4: begin
            for (int i = 0; i < span; i++) v.push_back(cur_name[8*i +: 8]);
            v.push_back(8'h00);
            repeat ($urandom_range(0, 3)) v.push_back(8'($urandom));
         end
         5: begin
            v.push_back(8'h00);
            repeat ($urandom_range(0, 3)) v.push_back(8'($urandom));
         end
         6: repeat ($urandom_range(26, 34)) v.push_back(8'($urandom_range(1, 255)));
         7: repeat ($urandom_range(0, 10)) v.push_back(8'($urandom));
         default: for (int i = 0; i < n; i++) v.push_back(cur_name[8*i +: 8]);
      endcase
   endfunction

   function automatic void fill_section(input int size, ref logic [7:0] sec[$]);
      int          room;
      int          kind;
      logic [7:0]  val[$];
      logic [7:0]  ftype;
      sec.delete();
      while (sec.size() < size) begin
         room = size - sec.size();
         kind = $urandom_range(0, 11);
         if (room == 1) begin
            sec.push_back(8'($urandom));
         end else if (kind == 0) begin
            sec.push_back(8'h00);
         end else if (kind == 1) begin
            sec.push_back(8'($urandom_range(room, 255)));
            while (sec.size() < size) sec.push_back(8'($urandom));
         end else begin
            if (kind <= 6) begin
               make_name(val);
               ftype = $urandom_range(0, 1) ? TYPE_FULL_NAME : TYPE_SHORT_NAME;
            end else begin
               val.delete();
               repeat ($urandom_range(0, 8)) val.push_back(8'($urandom));
               case ($urandom_range(0, 4))
                  0: ftype = 8'h01;
                  1: ftype = 8'hFF;
                  2: ftype = 8'h00;
                  default: ftype = 8'($urandom);
               endcase
            end
            while (val.size() > room - 2) void'(val.pop_back());
            sec.push_back(8'(val.size() + 1));
            sec.push_back(ftype);
            foreach (val[i]) sec.push_back(val[i]);
         end
      end
   endfunction

   function automatic void add_section(input logic resp);
      logic [7:0] sec[$];
      int         size;
      logic [7:0] slen;
      logic       kind;
      size = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 255) : $urandom_range(1, 24);
      fill_section(size, sec);
      foreach (sec[i]) begin
         slen = (i > 0 && $urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) :
                8'(size);
         kind = ($urandom_range(0, 19) == 0) ? ~resp : resp;
         add_word(sec[i], kind, slen, 1'b0);
         if ($urandom_range(0, 24) == 0) begin
            add_word(8'($urandom), 1'($urandom_range(0, 1)), 8'd0, 1'b0);
         end
      end
   endfunction

   function automatic void add_report();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++) begin
            add_word(8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     i == n - 1);
         end
      end else if (pick < 10) begin
         add_word(8'($urandom), 1'($urandom_range(0, 1)), 8'd0, 1'b1);
      end else begin
         if ($urandom_range(0, 9) != 0) add_section(1'b0);
         if ($urandom_range(0, 4) != 0) add_section(1'b1);
         pick = $urandom_range(0, 9);
         if (report_words.size() == 0 || (pick >= 5 && pick < 8)) begin
            add_word(8'($urandom), 1'($urandom_range(0, 1)), 8'd0, 1'b1);
         end else begin
            if (pick >= 8) begin
               n = $urandom_range(1, report_words.size());
               while (report_words.size() > n) void'(report_words.pop_back());
            end
            report_words[report_words.size() - 1].last_of_report = 1'b1;
         end
      end
   endfunction

   task automatic send_word(input req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic play_report();
      foreach (report_words[i]) begin
         send_word(report_words[i]);
         words_sent = words_sent + 1;
         if (report_words[i].last_of_report) reports_sent = reports_sent + 1;
      end
      report_words.delete();
   endtask

   task automatic wait_quiet();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {sel, 3'b000};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] printable_name();
      logic [63:0] v;
      for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
      return v;
   endfunction

   initial begin
      logic [63:0] names[SESSIONS];
      logic [3:0]  lens[SESSIONS];
      logic [7:0]  t0;
      logic [7:0]  t1;
      logic [7:0]  t2;
      int          goal;

      t0 = TARGET_NAME_RESET[7:0];
      t1 = TARGET_NAME_RESET[15:8];
      t2 = TARGET_NAME_RESET[23:16];

      names[0] = printable_name();   lens[0] = 4'd8;
      names[1] = 64'h0;              lens[1] = 4'd1;
      names[2] = printable_name();   lens[2] = 4'd0;
      names[3] = '1;                 lens[3] = 4'd8;
      names[4] = printable_name();   lens[4] = 4'd15;
      names[5] = printable_name();   lens[5] = 4'd5;
      names[5][23:16] = 8'h00;
      names[6] = printable_name();   lens[6] = 4'd1;
      names[7] = printable_name();   lens[7] = 4'd9;
      names[8] = printable_name();   lens[8] = 4'd4;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // target name in advertising
      add_word(8'h04, 1'b0, 8'd5, 1'b0);
      add_word(TYPE_FULL_NAME, 1'b0, 8'd5, 1'b0);
      add_word(t0, 1'b0, 8'd5, 1'b0);
      add_word(t1, 1'b0, 8'd5, 1'b0);
      add_word(t2, 1'b0, 8'd5, 1'b1);
      play_report();
      // overrun in advertising, short name in scan response, closed by an empty item
      add_word(8'h05, 1'b0, 8'd3, 1'b0);
      add_word(TYPE_SHORT_NAME, 1'b0, 8'd3, 1'b0);
      add_word(8'hFF, 1'b0, 8'd3, 1'b0);
      add_word(8'h02, 1'b1, 8'd3, 1'b0);
      add_word(TYPE_SHORT_NAME, 1'b1, 8'd3, 1'b0);
      add_word(t0, 1'b1, 8'd3, 1'b0);
      add_word(8'h00, 1'b0, 8'd0, 1'b1);
      play_report();
      // empty report
      add_word(8'h00, 1'b1, 8'd0, 1'b1);
      play_report();
      // zero-length field and empty name in advertising, name from scan response
      add_word(8'h00, 1'b0, 8'd4, 1'b0);
      add_word(8'h02, 1'b0, 8'd4, 1'b0);
      add_word(TYPE_FULL_NAME, 1'b0, 8'd4, 1'b0);
      add_word(8'h00, 1'b0, 8'd4, 1'b0);
      add_word(8'h02, 1'b1, 8'd3, 1'b0);
      add_word(TYPE_SHORT_NAME, 1'b1, 8'd3, 1'b0);
      add_word(8'hFF, 1'b1, 8'd3, 1'b1);
      play_report();
      // report cut inside a name
      add_word(8'h05, 1'b0, 8'd6, 1'b0);
      add_word(TYPE_FULL_NAME, 1'b0, 8'd6, 1'b0);
      add_word(t0, 1'b0, 8'd6, 1'b0);
      add_word(t1, 1'b0, 8'd6, 1'b1);
      play_report();
      // longest section with an overrunning length byte
      add_word(8'hFF, 1'b0, 8'd255, 1'b1);
      play_report();
      // lone trailing length byte
      add_word(8'h05, 1'b1, 8'd1, 1'b1);
      play_report();
      req_valid <= 1'b0;

      for (int s = 0; s < SESSIONS; s++) begin
         wait_quiet();
         write_csr(REG_TARGET_NAME, names[s]);
         write_csr(REG_TARGET_LENGTH, {60'd0, lens[s]});
         cur_name = names[s];
         cur_len  = lens[s];
         if (s < 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 86;
         end else if (s < 6) begin
            send_idle_pct = 86;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (s == 6) hold_kick <= ~hold_kick;
         goal = words_sent + SESSION_WORDS;
         while (words_sent < goal) begin
            add_report();
            play_report();
         end
         req_valid <= 1'b0;
      end

      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d words in %0d scan reports under %0d target settings.",
               words_sent, reports_sent, SESSIONS + 1);
      $display("Checked %0d result words, %0d of them name matches.",
               results_seen, matches_seen);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches found", fail_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
